// ===== rtl/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, register codes and types for the fractal value noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package fvn_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int FREQ_FRAC       = 16;
  localparam int COORD_W         = 48;
  localparam int OUT_W           = FRAC_BITS + 2;
  localparam int VAL_W           = FRAC_BITS + 1;
  localparam int W_W             = FRAC_BITS + 1;
  localparam int PROD_W          = VAL_W + 33;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 64;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] Y_OFFSET    = 64'hC2B2_AE3D_27D4_EB4F;
  localparam logic [63:0] MUL_A       = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL_B       = 64'h94D0_49BB_1331_11EB;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_SEED    = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;
  localparam logic [1:0] REG_LACUN   = 2'd3;

  localparam logic [63:0] RST_SEED    = 64'd0;
  localparam logic [3:0]  RST_COUNT   = 4'd1;
  localparam logic [16:0] RST_PERSIST = 17'd32768;
  localparam logic [18:0] RST_LACUN   = 19'd131072;

  typedef struct packed {
    logic [63:0] seed;
    logic [3:0]  octave_count;
    logic [16:0] persistence;
    logic [18:0] lacunarity;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic        empty;
    logic [31:0] amp;
  } oct_tag_t;

endpackage

`default_nettype wire

// ===== rtl/fractal_value_noise_2d.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal value noise over a 2D point with APB-style configuration registers.
// ----------------------------------------------------------------------------
// throughput: one octave per cycle through the octave pipeline unless the output
//   stalls; the octaves of each item are issued right behind those of the one before
// a four-entry input queue keeps accepting while the back end or output stalls, until full
// reset: synchronous, clears queue, pipeline valids and output valid; registers
//   return to seed 0, one octave, persistence 0.5, lacunarity 2.0
`default_nettype none

module fractal_value_noise_2d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      coord_valid,
  output logic                      coord_ready,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  output logic                      noise_valid,
  input  logic                      noise_ready,
  output logic signed [OUT_W-1:0]   noise_value,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int CNT_W = $clog2(MAX_OCTAVES+1);
  localparam int SUM_W = PROD_W + CNT_W;
  localparam int TOT_W = 32 + CNT_W;

  cfg_t                      cfg;
  logic                      en;
  logic                      head_valid;
  logic signed [COORD_W-1:0] head_x, head_y;
  logic                      pop;
  logic                      sum_valid;
  logic                      sum_empty;
  logic signed [SUM_W-1:0]   sum;
  logic [TOT_W-1:0]          tot;
  logic                      res_valid;
  logic signed [OUT_W-1:0]   res_value;
  logic [1:0]                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign en      = !noise_valid || noise_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed         <= RST_SEED;
      cfg.octave_count <= RST_COUNT;
      cfg.persistence  <= RST_PERSIST;
      cfg.lacunarity   <= RST_LACUN;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SEED:    cfg.seed         <= pwdata;
        REG_COUNT:   cfg.octave_count <= pwdata[3:0];
        REG_PERSIST: cfg.persistence  <= pwdata[16:0];
        REG_LACUN:   cfg.lacunarity   <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEED:    prdata = cfg.seed;
      REG_COUNT:   prdata = DATA_W'(cfg.octave_count);
      REG_PERSIST: prdata = DATA_W'(cfg.persistence);
      REG_LACUN:   prdata = DATA_W'(cfg.lacunarity);
      default:     prdata = '0;
    endcase
  end

  fvn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_ready (coord_ready),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .head_valid  (head_valid),
    .head_x      (head_x),
    .head_y      (head_y),
    .pop         (pop)
  );

  fvn_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_x     (head_x),
    .head_y     (head_y),
    .pop        (pop),
    .sum_valid  (sum_valid),
    .sum_empty  (sum_empty),
    .sum        (sum),
    .tot        (tot)
  );

  fvn_div #(.MAX_OCTAVES(MAX_OCTAVES)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sum_valid),
    .in_empty  (sum_empty),
    .in_sum    (sum),
    .in_tot    (tot),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_valid <= 1'b0;
    end else if (en) begin
      noise_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise_value <= res_value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvn_front.sv =====
// ----------------------------------------------------------------------------
// fvn_front
// Input side: accepts coordinate items and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_front import fvn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      coord_valid,
  output logic                      coord_ready,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  output logic                      head_valid,
  output logic signed [COORD_W-1:0] head_x,
  output logic signed [COORD_W-1:0] head_y,
  input  logic                      pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [COORD_W-1:0] qx [QUEUE_DEPTH];
  logic [COORD_W-1:0] qy [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pull;

  assign coord_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid  = (count != '0);
  assign head_x      = $signed(qx[rd_ptr]);
  assign head_y      = $signed(qy[rd_ptr]);
  assign push        = coord_valid && coord_ready;
  assign pull        = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      qx[wr_ptr] <= coord_x;
      qy[wr_ptr] <= coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pull) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pull) begin
        count <= count + 1'b1;
      end else if (pull && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvn_mix.sv =====
// ----------------------------------------------------------------------------
// fvn_mix
// Five-stage splitmix64 finalizer, 64-bit products split into 32-bit parts.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_mix import fvn_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] din,
  output logic [63:0] dout
);

  logic [63:0] a;
  logic [63:0] s1;
  logic [63:0] ll_a;
  logic [31:0] lh_a;
  logic [31:0] hl_a;
  logic [63:0] m_a;
  logic [63:0] s3;
  logic [63:0] ll_b;
  logic [31:0] lh_b;
  logic [31:0] hl_b;
  logic [63:0] m_b;

  always_comb begin
    a   = din + GOLDEN_STEP;
    m_a = ll_a + {lh_a + hl_a, 32'b0};
    m_b = ll_b + {lh_b + hl_b, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= a ^ (a >> 30);
      ll_a <= 64'(s1[31:0]) * 64'(MUL_A[31:0]);
      lh_a <= s1[31:0] * MUL_A[63:32];
      hl_a <= s1[63:32] * MUL_A[31:0];
      s3   <= m_a ^ (m_a >> 27);
      ll_b <= 64'(s3[31:0]) * 64'(MUL_B[31:0]);
      lh_b <= s3[31:0] * MUL_B[63:32];
      hl_b <= s3[63:32] * MUL_B[31:0];
      dout <= m_b ^ (m_b >> 31);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvn_octave.sv =====
// ----------------------------------------------------------------------------
// fvn_octave
// Seventeen-stage pipeline that evaluates one octave of value noise a cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_octave import fvn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  oct_tag_t                 tag_in,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic [31:0]              freq,
  input  logic [63:0]              seed,
  output oct_tag_t                 tag_out,
  output logic signed [VAL_W-1:0]  value
);

  localparam int HALF     = COORD_W / 2;
  localparam int PL_W     = HALF + 32;
  localparam int PH_W     = COORD_W - HALF + 33;
  localparam int CELL_LSB = FREQ_FRAC + FRAC_BITS;
  localparam int SEED_DLY = 8;
  localparam int W_DLY    = 13;
  localparam int TAG_DLY  = 17;
  localparam int MUL_W    = VAL_W + W_W + 2;
  localparam logic [FRAC_BITS+1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

  logic [PL_W-1:0]          pxl, pyl;
  logic signed [PH_W-1:0]   pxh, pyh;
  logic [63:0]              sx, sy;
  logic [31:0]              cellx, celly, cellx1, celly1;
  logic [FRAC_BITS-1:0]     fx, fy;
  logic [63:0]              ax0, ax1, ay0, ay1;
  logic [2*FRAC_BITS-1:0]   sqx, sqy;
  logic [FRAC_BITS-1:0]     f2x, f2y;
  logic [FRAC_BITS+1:0]     tx, ty;
  logic [2*FRAC_BITS+1:0]   ex, ey;
  logic [W_W-1:0]           wxp [W_DLY];
  logic [W_W-1:0]           wyp [W_DLY];
  logic [63:0]              seedp [SEED_DLY];
  logic [63:0]              hx0, hx1, hy0, hy1;
  logic [63:0]              k00, k10, k01, k11;
  logic [63:0]              h00, h10, h01, h11;
  logic signed [VAL_W-1:0]  c00, c10, c01, c11;
  logic signed [VAL_W-1:0]  upper, lower;
  logic signed [VAL_W:0]    du, dl, dv;
  logic signed [MUL_W-1:0]  pu, pl, pv;
  oct_tag_t                 tagp [TAG_DLY];

  always_comb begin
    sx     = {pxh[63-HALF:0], {HALF{1'b0}}} + 64'(pxl);
    sy     = {pyh[63-HALF:0], {HALF{1'b0}}} + 64'(pyl);
    cellx1 = cellx + 32'd1;
    celly1 = celly + 32'd1;
    sqx    = fx * fx;
    sqy    = fy * fy;
    ex     = f2x * tx;
    ey     = f2y * ty;
    du     = (VAL_W+1)'(c10) - (VAL_W+1)'(c00);
    dl     = (VAL_W+1)'(c11) - (VAL_W+1)'(c01);
    pu     = du * $signed({1'b0, wxp[W_DLY-2]});
    pl     = dl * $signed({1'b0, wxp[W_DLY-2]});
    dv     = (VAL_W+1)'(lower) - (VAL_W+1)'(upper);
    pv     = dv * $signed({1'b0, wyp[W_DLY-1]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl    <= PL_W'(cx[HALF-1:0]) * PL_W'(freq);
      pyl    <= PL_W'(cy[HALF-1:0]) * PL_W'(freq);
      pxh    <= $signed(cx[COORD_W-1:HALF]) * $signed({1'b0, freq});
      pyh    <= $signed(cy[COORD_W-1:HALF]) * $signed({1'b0, freq});
      cellx  <= sx[CELL_LSB+31:CELL_LSB];
      celly  <= sy[CELL_LSB+31:CELL_LSB];
      fx     <= sx[CELL_LSB-1:FREQ_FRAC];
      fy     <= sy[CELL_LSB-1:FREQ_FRAC];
      ax0    <= {{32{cellx[31]}}, cellx} + GOLDEN_STEP;
      ax1    <= {{32{cellx1[31]}}, cellx1} + GOLDEN_STEP;
      ay0    <= {{32{celly[31]}}, celly} + Y_OFFSET;
      ay1    <= {{32{celly1[31]}}, celly1} + Y_OFFSET;
      f2x    <= sqx[2*FRAC_BITS-1:FRAC_BITS];
      f2y    <= sqy[2*FRAC_BITS-1:FRAC_BITS];
      tx     <= THREE_ONE - {1'b0, fx, 1'b0};
      ty     <= THREE_ONE - {1'b0, fy, 1'b0};
      wxp[0] <= ex[2*FRAC_BITS:FRAC_BITS];
      wyp[0] <= ey[2*FRAC_BITS:FRAC_BITS];
      for (int i = 1; i < W_DLY; i++) begin
        wxp[i] <= wxp[i-1];
        wyp[i] <= wyp[i-1];
      end
      seedp[0] <= seed;
      for (int i = 1; i < SEED_DLY; i++) begin
        seedp[i] <= seedp[i-1];
      end
      k00    <= seedp[SEED_DLY-1] ^ hx0 ^ hy0;
      k10    <= seedp[SEED_DLY-1] ^ hx1 ^ hy0;
      k01    <= seedp[SEED_DLY-1] ^ hx0 ^ hy1;
      k11    <= seedp[SEED_DLY-1] ^ hx1 ^ hy1;
      c00    <= {~h00[63], h00[62:63-FRAC_BITS]};
      c10    <= {~h10[63], h10[62:63-FRAC_BITS]};
      c01    <= {~h01[63], h01[62:63-FRAC_BITS]};
      c11    <= {~h11[63], h11[62:63-FRAC_BITS]};
      upper  <= c00 + pu[VAL_W+FRAC_BITS-1:FRAC_BITS];
      lower  <= c01 + pl[VAL_W+FRAC_BITS-1:FRAC_BITS];
      value  <= upper + pv[VAL_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_DLY; i++) begin
        tagp[i] <= '0;
      end
    end else if (en) begin
      tagp[0] <= tag_in;
      for (int i = 1; i < TAG_DLY; i++) begin
        tagp[i] <= tagp[i-1];
      end
    end
  end

  assign tag_out = tagp[TAG_DLY-1];

  fvn_mix u_mix_x0 (.clk(clk), .en(en), .din(ax0), .dout(hx0));
  fvn_mix u_mix_x1 (.clk(clk), .en(en), .din(ax1), .dout(hx1));
  fvn_mix u_mix_y0 (.clk(clk), .en(en), .din(ay0), .dout(hy0));
  fvn_mix u_mix_y1 (.clk(clk), .en(en), .din(ay1), .dout(hy1));

  fvn_mix u_mix_c00 (.clk(clk), .en(en), .din(k00), .dout(h00));
  fvn_mix u_mix_c10 (.clk(clk), .en(en), .din(k10), .dout(h10));
  fvn_mix u_mix_c01 (.clk(clk), .en(en), .din(k01), .dout(h01));
  fvn_mix u_mix_c11 (.clk(clk), .en(en), .din(k11), .dout(h11));

endmodule

`default_nettype wire

// ===== rtl/fvn_back.sv =====
// ----------------------------------------------------------------------------
// fvn_back
// Octave sequencer, octave pipeline and weighted accumulation of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_back import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  cfg_t                       cfg,
  input  logic                       head_valid,
  input  logic signed [COORD_W-1:0]  head_x,
  input  logic signed [COORD_W-1:0]  head_y,
  output logic                       pop,
  output logic                       sum_valid,
  output logic                       sum_empty,
  output logic signed [PROD_W+$clog2(MAX_OCTAVES+1)-1:0] sum,
  output logic [32+$clog2(MAX_OCTAVES+1)-1:0]             tot
);

  localparam int CNT_W = $clog2(MAX_OCTAVES+1);
  localparam int SUM_W = PROD_W + CNT_W;
  localparam int TOT_W = 32 + CNT_W;

  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         cnt;
  logic                     is_empty;
  logic                     iss_last;
  logic [31:0]              iss_freq, iss_amp;
  logic [63:0]              iss_seed;
  logic [50:0]              fprod;
  logic [48:0]              aprod;
  logic [31:0]              freq, freq_next;
  logic [31:0]              amp, amp_next;
  logic [63:0]              seed;
  oct_tag_t                 iss_tag;
  oct_tag_t                 otag;
  oct_tag_t                 ptag;
  logic signed [VAL_W-1:0]  ovalue;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc, acc_next;
  logic [TOT_W-1:0]         acc_tot, tot_next;

  always_comb begin
    if (int'(cfg.octave_count) > MAX_OCTAVES) begin
      cnt = CNT_W'(MAX_OCTAVES);
    end else begin
      cnt = CNT_W'(cfg.octave_count);
    end
    is_empty = (cnt == '0);
    iss_last = is_empty || (k == CNT_W'(cnt - 1'b1));
    iss_freq = (k == '0) ? ONE_Q16 : freq;
    iss_amp  = (k == '0) ? ONE_Q16 : amp;
    iss_seed = (k == '0) ? cfg.seed : seed;
    fprod    = 51'(iss_freq) * 51'(cfg.lacunarity);
    aprod    = 49'(iss_amp) * 49'(cfg.persistence);
    freq_next = (|fprod[50:48]) ? SAT32 : fprod[47:16];
    amp_next  = aprod[48] ? SAT32 : aprod[47:16];
    iss_tag.valid = head_valid;
    iss_tag.first = (k == '0);
    iss_tag.last  = iss_last;
    iss_tag.empty = is_empty;
    iss_tag.amp   = iss_amp;
    pop      = en && head_valid && iss_last;
    acc_next = (ptag.first ? '0 : acc) + SUM_W'(prod);
    tot_next = (ptag.first ? '0 : acc_tot) + TOT_W'(ptag.amp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (en && head_valid) begin
      k <= iss_last ? '0 : k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && head_valid) begin
      freq <= freq_next;
      amp  <= amp_next;
      seed <= iss_seed + GOLDEN_STEP;
    end
  end

  fvn_octave u_octave (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (iss_tag),
    .cx      (head_x),
    .cy      (head_y),
    .freq    (iss_freq),
    .seed    (iss_seed),
    .tag_out (otag),
    .value   (ovalue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptag      <= '0;
      sum_valid <= 1'b0;
    end else if (en) begin
      ptag      <= otag;
      sum_valid <= ptag.valid && ptag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= ovalue * $signed({1'b0, otag.amp});
      sum       <= acc_next;
      tot       <= tot_next;
      sum_empty <= ptag.empty;
      if (ptag.valid) begin
        acc     <= acc_next;
        acc_tot <= tot_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvn_div.sv =====
// ----------------------------------------------------------------------------
// fvn_div
// Pipelined restoring divider, one quotient bit a stage, signed truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_div import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic                    in_empty,
  input  logic signed [PROD_W+$clog2(MAX_OCTAVES+1)-1:0] in_sum,
  input  logic [32+$clog2(MAX_OCTAVES+1)-1:0]             in_tot,
  output logic                    res_valid,
  output logic signed [OUT_W-1:0] res_value
);

  localparam int CNT_W = $clog2(MAX_OCTAVES+1);
  localparam int SUM_W = PROD_W + CNT_W;
  localparam int TOT_W = 32 + CNT_W;
  localparam int QB    = FRAC_BITS + 1;
  localparam logic [QB-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  logic [SUM_W-1:0] rem   [QB+1];
  logic [QB-1:0]    qv    [QB+1];
  logic [TOT_W-1:0] tots  [QB+1];
  logic             negs  [QB+1];
  logic             emps  [QB+1];
  logic             vld   [QB+1];
  logic [SUM_W-1:0] dvs   [QB];
  logic             ge    [QB];
  logic [QB-1:0]    qc;
  logic [OUT_W-1:0] qx;

  always_comb begin
    for (int j = 1; j <= QB; j++) begin
      dvs[j-1] = SUM_W'(tots[j-1]) << (QB - j);
      ge[j-1]  = (rem[j-1] >= dvs[j-1]);
    end
    qc = (qv[QB] > ONE_Q) ? ONE_Q : qv[QB];
    qx = OUT_W'(qc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
      qv[0]   <= '0;
      tots[0] <= in_tot;
      negs[0] <= in_sum[SUM_W-1];
      emps[0] <= in_empty;
      for (int j = 1; j <= QB; j++) begin
        rem[j]  <= ge[j-1] ? rem[j-1] - dvs[j-1] : rem[j-1];
        qv[j]   <= {qv[j-1][QB-2:0], ge[j-1]};
        tots[j] <= tots[j-1];
        negs[j] <= negs[j-1];
        emps[j] <= emps[j-1];
      end
      if (emps[QB]) begin
        res_value <= '0;
      end else if (negs[QB]) begin
        res_value <= -qx;
      end else begin
        res_value <= qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QB; j++) begin
        vld[j] <= 1'b0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 1; j <= QB; j++) begin
        vld[j] <= vld[j-1];
      end
      res_valid <= vld[QB];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fvn_checker.sv =====
// ----------------------------------------------------------------------------
// fvn_checker
// Port-level checks on the fractal value noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fvn_checker import fvn_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      coord_ready,
  input logic                      noise_valid,
  input logic                      noise_ready,
  input logic signed [OUT_W-1:0]   noise_value,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [ADDR_W-1:0]         paddr,
  input logic [DATA_W-1:0]         pwdata,
  input logic [DATA_W-1:0]         prdata
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !noise_valid && coord_ready)
    else $error("output valid or input stall after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    noise_valid && !noise_ready |=> noise_valid && $stable(noise_value))
    else $error("result dropped or changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    noise_valid |-> (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536))
    else $error("noise value outside [-1, 1]");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == '0) |=>
      (paddr != '0) || pwrite || (prdata == $past(pwdata)))
    else $error("seed register read differs from last write");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (.*);

`default_nettype wire
